[sv/twsa_pkg.sv]
// Shared types, codes and microprogram for the time window sample averager.
package twsa_pkg;

  // Default store depth and register reset values
  localparam int unsigned DEPTH_DEFAULT   = 256;
  localparam logic [31:0] SCALE_RESET     = 32'h0001_0000;
  localparam logic [19:0] WINDOW_RESET    = 20'd1000;

  // Configuration port
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b1;

  // Field widths
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned WINDOW_W = 20;
  localparam int unsigned PROD_W   = CODE_W + VALUE_W;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned IN_DATA_W = ((CODE_W + TIME_W + 7) / 8) * 8;

  // Microprogram step counter
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Datapath actions
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_LATCH,
    ACT_MUL,
    ACT_SCALE,
    ACT_DROP,
    ACT_DROP_FULL,
    ACT_APPEND,
    ACT_DIV_LOAD,
    ACT_DIV_STEP,
    ACT_EMIT
  } act_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_KEEP,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctl_word_t;

  // Sequencer to datapath
  typedef struct packed {
    act_t act;
    logic en;
  } dp_ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic need_evict;
    logic div_busy;
    logic out_busy;
  } dp_stat_t;

  // Program steps
  localparam step_t S_WAIT     = 4'd0;
  localparam step_t S_MUL      = 4'd1;
  localparam step_t S_SCALE    = 4'd2;
  localparam step_t S_CHECK    = 4'd3;
  localparam step_t S_EVICT    = 4'd4;
  localparam step_t S_REREAD   = 4'd5;
  localparam step_t S_FULL     = 4'd6;
  localparam step_t S_APPEND   = 4'd7;
  localparam step_t S_DIV_LOAD = 4'd8;
  localparam step_t S_DIV_STEP = 4'd9;
  localparam step_t S_EMIT     = 4'd10;
  localparam step_t S_DONE     = 4'd11;

  // Control store: one word per step, jump to target when the condition holds
  function automatic ctl_word_t micro_rom(input step_t step);
    ctl_word_t w;
    unique case (step)
      S_WAIT:     w = '{ACT_LATCH,     COND_NO_INPUT, S_WAIT};
      S_MUL:      w = '{ACT_MUL,       COND_NEVER,    S_WAIT};
      S_SCALE:    w = '{ACT_SCALE,     COND_NEVER,    S_WAIT};
      S_CHECK:    w = '{ACT_NOP,       COND_KEEP,     S_FULL};
      S_EVICT:    w = '{ACT_DROP,      COND_NEVER,    S_WAIT};
      S_REREAD:   w = '{ACT_NOP,       COND_ALWAYS,   S_CHECK};
      S_FULL:     w = '{ACT_DROP_FULL, COND_NEVER,    S_WAIT};
      S_APPEND:   w = '{ACT_APPEND,    COND_NEVER,    S_WAIT};
      S_DIV_LOAD: w = '{ACT_DIV_LOAD,  COND_NEVER,    S_WAIT};
      S_DIV_STEP: w = '{ACT_DIV_STEP,  COND_DIV_BUSY, S_DIV_STEP};
      S_EMIT:     w = '{ACT_EMIT,      COND_OUT_BUSY, S_EMIT};
      S_DONE:     w = '{ACT_NOP,       COND_ALWAYS,   S_WAIT};
      default:    w = '{ACT_NOP,       COND_ALWAYS,   S_WAIT};
    endcase
    return w;
  endfunction

endpackage

[sv/twsa_seq.sv]
// Microprogram sequencer: step counter, control store lookup and jumps.
module twsa_seq
  import twsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  step_t     upc_r;
  step_t     upc_nxt;
  ctl_word_t word;
  logic      jump;

  assign word = micro_rom(upc_r);

  // Evaluate the jump condition of the current step
  always_comb begin
    unique case (word.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_INPUT: jump = !in_tvalid;
      COND_KEEP:     jump = !stat.need_evict;
      COND_DIV_BUSY: jump = stat.div_busy;
      COND_OUT_BUSY: jump = stat.out_busy;
      default:       jump = 1'b1;
    endcase
  end

  assign upc_nxt = jump ? word.target : upc_r + step_t'(1);

  // Gate the actions that wait on a handshake
  always_comb begin
    ctl.act = word.act;
    unique case (word.act)
      ACT_LATCH: ctl.en = in_tvalid;
      ACT_EMIT:  ctl.en = !stat.out_busy;
      default:   ctl.en = 1'b1;
    endcase
  end

  assign in_tready = (word.act == ACT_LATCH);

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

[sv/twsa_div.sv]
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module twsa_div
  import twsa_pkg::*;
#(
  parameter int unsigned SUM_W = 40,
  parameter int unsigned CNT_W = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic                    step,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    busy,
  output logic [VALUE_W-1:0]      quotient
);

  localparam int unsigned ITER_W = $clog2(SUM_W + 1);

  logic              neg_r;
  logic [SUM_W-1:0]  q_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  den_r;
  logic [ITER_W-1:0] cnt_r;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;

  assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign rem_sh  = {rem_r, q_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});

  // Load operands, then shift one bit per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= ITER_W'(SUM_W);
    end else if (step) begin
      cnt_r <= cnt_r - ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= dividend[SUM_W-1];
      q_r   <= mag;
      rem_r <= '0;
      den_r <= divisor;
    end else if (step) begin
      q_r   <= {q_r[SUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  // The last step runs while the counter reads one; idle reads zero
  assign busy     = (cnt_r > ITER_W'(1));
  assign quotient = neg_r ? VALUE_W'(-q_r[VALUE_W-1:0]) : q_r[VALUE_W-1:0];

endmodule

[sv/twsa_dp.sv]
// Datapath: registers, gain multiplier, sample store, running sum and result stage.
module twsa_dp
  import twsa_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_ctl_t               ctl,
  output dp_stat_t              stat,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CODE_W-1:0]     in_code,
  input  logic [TIME_W-1:0]     in_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_W-1:0]    out_scaled,
  output logic [VALUE_W-1:0]    out_mean,
  output logic [CNT_W-1:0]      out_count,
  output logic                  out_dropped
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned SUM_W = VALUE_W + IDX_W;
  localparam int unsigned SLOT_W = IDX_W + 2;

  // Configuration
  logic signed [VALUE_W-1:0]  scale_r;
  logic [WINDOW_W-1:0]        window_r;

  // Item registers
  logic signed [CODE_W-1:0]   code_r;
  logic [TIME_W-1:0]          now_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [VALUE_W-1:0]         scaled_r;
  logic                       dropped_r;

  // Window state
  logic [IDX_W-1:0]           oldest_r;
  logic [CNT_W-1:0]           count_r;
  logic signed [SUM_W-1:0]    sum_r;

  // Sample store: time in the upper half, value in the lower
  logic [TIME_W+VALUE_W-1:0]  mem [DEPTH];
  logic [TIME_W+VALUE_W-1:0]  rd_r;

  // Result stage
  logic                       out_valid_r;
  logic [VALUE_W-1:0]         out_scaled_r;
  logic [VALUE_W-1:0]         out_mean_r;
  logic [CNT_W-1:0]           out_count_r;
  logic                       out_dropped_r;

  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [SUM_W-1:0]    rd_val;
  logic signed [SUM_W-1:0]    new_val;
  logic [TIME_W-1:0]          age;
  logic [IDX_W:0]             oldest_inc;
  logic [IDX_W-1:0]           oldest_nxt;
  logic [SLOT_W-1:0]          slot_sum;
  logic [IDX_W-1:0]           slot;
  logic                       is_full;
  logic                       do_drop;
  logic                       div_busy;
  logic [VALUE_W-1:0]         quotient;

  assign prod_nxt   = PROD_W'(code_r) * PROD_W'(scale_r);
  assign rd_val     = SUM_W'($signed(rd_r[VALUE_W-1:0]));
  assign new_val    = SUM_W'($signed(scaled_r));
  assign age        = now_r - rd_r[TIME_W+VALUE_W-1:VALUE_W];
  assign oldest_inc = {1'b0, oldest_r} + (IDX_W+1)'(1);
  assign oldest_nxt = (oldest_inc == (IDX_W+1)'(DEPTH)) ? '0 : oldest_inc[IDX_W-1:0];
  assign slot_sum   = SLOT_W'(oldest_r) + SLOT_W'(count_r);
  assign slot       = (slot_sum >= SLOT_W'(DEPTH)) ?
                      IDX_W'(slot_sum - SLOT_W'(DEPTH)) : IDX_W'(slot_sum);
  assign is_full    = (count_r == CNT_W'(DEPTH));
  assign do_drop    = ctl.en && ((ctl.act == ACT_DROP) ||
                                 (ctl.act == ACT_DROP_FULL && is_full));

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      window_r <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SCALE:  scale_r  <= cfg_data;
        REG_WINDOW: window_r <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item, multiply, take the floor of the Q16.16 product
  always_ff @(posedge clk) begin
    if (ctl.en && ctl.act == ACT_LATCH) begin
      code_r <= in_code;
      now_r  <= in_time;
    end
    if (ctl.en && ctl.act == ACT_MUL) begin
      prod_r <= prod_nxt;
    end
    if (ctl.en && ctl.act == ACT_SCALE) begin
      scaled_r <= prod_r[FRAC_W+VALUE_W-1:FRAC_W];
    end
  end

  // Track the window: drop oldest, append newest, keep the running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r  <= '0;
      count_r   <= '0;
      sum_r     <= '0;
      dropped_r <= 1'b0;
    end else begin
      if (ctl.en && ctl.act == ACT_LATCH) begin
        dropped_r <= 1'b0;
      end
      if (do_drop) begin
        sum_r    <= sum_r - rd_val;
        oldest_r <= oldest_nxt;
        count_r  <= count_r - CNT_W'(1);
        if (ctl.act == ACT_DROP_FULL) begin
          dropped_r <= 1'b1;
        end
      end
      if (ctl.en && ctl.act == ACT_APPEND) begin
        sum_r   <= sum_r + new_val;
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // Store port: write on append, read the oldest entry every cycle
  always_ff @(posedge clk) begin
    if (ctl.en && ctl.act == ACT_APPEND) begin
      mem[slot] <= {now_r, scaled_r};
    end
    rd_r <= mem[oldest_r];
  end

  twsa_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ctl.en && ctl.act == ACT_DIV_LOAD),
    .step     (ctl.en && ctl.act == ACT_DIV_STEP),
    .dividend (sum_r),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Result register: load when free, hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.en && ctl.act == ACT_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.act == ACT_EMIT) begin
      out_scaled_r  <= scaled_r;
      out_mean_r    <= quotient;
      out_count_r   <= count_r;
      out_dropped_r <= dropped_r;
    end
  end

  assign stat.need_evict = (count_r != '0) && (age > TIME_W'(window_r));
  assign stat.div_busy   = div_busy;
  assign stat.out_busy   = out_valid_r && !out_ready;

  assign out_valid   = out_valid_r;
  assign out_scaled  = out_scaled_r;
  assign out_mean    = out_mean_r;
  assign out_count   = out_count_r;
  assign out_dropped = out_dropped_r;

endmodule

[sv/time_window_sample_averager.sv]
// Top level of the time window sample averager: ports, sequencer and datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in_     | input     | in_tvalid/tready   | sample_code, timestamp_ms
//  out_    | output    | out_tvalid/tready  | scaled_value, mean_value, sample_count,
//          |           |                    | overflow_dropped
//  cfg_    | input     | cfg_wr_en          | 0: scale_factor, 1: window_ms
//
// An item holds the block from its accepting step until its result is loaded; each
// sample aged out costs a check, a drop and a store re-read, and the 40-step serial
// divider for the mean takes most of the steps of an item with no evictions.
// Reset clears the step counter, window pointers, sum and result valid; the store
// needs no clearing since only written entries are read.
// A stalled result stays in its register while the next item is worked on; the
// sequencer waits at the load of the result register until the old one is taken.
module time_window_sample_averager
  import twsa_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEPTH_DEFAULT,
  parameter int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1),
  parameter int unsigned OUT_DATA_W   = ((2 * VALUE_W + CNT_W + 1 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_code[15:0], timestamp_ms[47:16]
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // scaled_value, mean_value, sample_count,
                                            // overflow_dropped, zero pad
);

  dp_ctl_t            ctl;
  dp_stat_t           stat;
  logic [VALUE_W-1:0] scaled;
  logic [VALUE_W-1:0] mean;
  logic [CNT_W-1:0]   count;
  logic               dropped;

  twsa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  twsa_dp #(
    .DEPTH (WINDOW_DEPTH),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_code     (in_tdata[CODE_W-1:0]),
    .in_time     (in_tdata[CODE_W+TIME_W-1:CODE_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_scaled  (scaled),
    .out_mean    (mean),
    .out_count   (count),
    .out_dropped (dropped)
  );

  // Pack result fields from the lowest bit up
  assign out_tdata = OUT_DATA_W'({dropped, count, mean, scaled});

  // A result always holds at least one sample and never more than the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (count != '0) && (count <= CNT_W'(WINDOW_DEPTH)))
    else $error("sample count out of range");

  // A forced drop leaves the store full again after the append
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && dropped) |-> (count == CNT_W'(WINDOW_DEPTH)))
    else $error("drop flag without full store");

  // One item at a time: ready falls after an accepted transaction
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted while busy");

  // The sequencer only offers ready at its latch step
  a_ready_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (ctl.act == ACT_LATCH) && !stat.div_busy)
    else $error("ready outside the idle step");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the time window sample averager stream block.
module testbench
  import twsa_pkg::*;
();

  localparam int unsigned DEPTH    = DEPTH_DEFAULT;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W    = ((2 * VALUE_W + CNT_BITS + 1 + 7) / 8) * 8;
  localparam longint      S32_MAX  = 64'sd2147483647;
  localparam longint      S32_MIN  = -64'sd2147483648;
  localparam int unsigned WIN_MAX  = 1000000;

  typedef struct {
    logic signed [31:0] scaled;
    logic signed [31:0] mean;
    logic [CNT_BITS-1:0] count;
    logic                dropped;
  } window_result_t;

  // Predicts the window averager and checks its results in order
  class window_scoreboard;
    logic signed [31:0] value_mem [DEPTH];
    logic [31:0]        stamp_mem [DEPTH];
    int unsigned        head;
    int unsigned        held;
    longint             run_sum;
    logic signed [31:0] gain;
    logic [WINDOW_W-1:0] win;
    window_result_t     expected_q [$];
    int unsigned        fails;

    function new();
      head    = 0;
      held    = 0;
      run_sum = 0;
      gain    = SCALE_RESET;
      win     = WINDOW_RESET;
      fails   = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
      case (idx)
        REG_SCALE:  gain = data;
        REG_WINDOW: win  = data[WINDOW_W-1:0];
        default: ;
      endcase
    endfunction

    function void drop_oldest();
      run_sum -= longint'(value_mem[head]);
      head = (head + 1) % DEPTH;
      held--;
    endfunction

    // Scale, age out, append and average one accepted sample
    function void note_input(input logic signed [15:0] code, input logic [31:0] stamp);
      longint         prod;
      longint         q;
      longint         mean;
      logic [31:0]    age;
      int unsigned    slot;
      window_result_t r;
      prod = longint'(code) * longint'(gain);
      q    = prod >>> FRAC_W;
      if (q > S32_MAX) q = S32_MAX;
      else if (q < S32_MIN) q = S32_MIN;
      r.dropped = 1'b0;
      while (held > 0) begin
        age = stamp - stamp_mem[head];
        if (age <= {12'd0, win}) break;
        drop_oldest();
      end
      if (held >= DEPTH) begin
        drop_oldest();
        r.dropped = 1'b1;
      end
      slot = (head + held) % DEPTH;
      value_mem[slot] = q[31:0];
      stamp_mem[slot] = stamp;
      held++;
      run_sum += q;
      mean = run_sum / longint'(held);
      r.scaled = q[31:0];
      r.mean   = mean[31:0];
      r.count  = held[CNT_BITS-1:0];
      expected_q = {expected_q, r};
    endfunction

    function void check_result(input logic [OUT_W-1:0] d);
      window_result_t e;
      logic signed [31:0]  got_scaled;
      logic signed [31:0]  got_mean;
      logic [CNT_BITS-1:0] got_count;
      logic                got_dropped;
      got_scaled  = d[31:0];
      got_mean    = d[63:32];
      got_count   = d[64 +: CNT_BITS];
      got_dropped = d[64 + CNT_BITS];
      if (expected_q.size() == 0) begin
        $error("result transaction with no expectation waiting: %h", d);
        fails++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (got_scaled !== e.scaled) begin
        $error("scaled_value: expected %0d, actual %0d", e.scaled, got_scaled);
        fails++;
      end
      if (got_mean !== e.mean) begin
        $error("mean_value: expected %0d, actual %0d", e.mean, got_mean);
        fails++;
      end
      if (got_count !== e.count) begin
        $error("sample_count: expected %0d, actual %0d", e.count, got_count);
        fails++;
      end
      if (got_dropped !== e.dropped) begin
        $error("overflow_dropped: expected %0d, actual %0d", e.dropped, got_dropped);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // sample_code[15:0], timestamp_ms[47:16]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;       // scaled_value, mean_value, sample_count,
                                          // overflow_dropped, zero pad

  window_scoreboard sb = new();
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 56;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  logic [31:0] clock_ms;

  time_window_sample_averager DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Check each result transaction; stall at random, and once for a long stretch
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
      results_seen++;
      if (results_seen == 300) hold_left = 500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one sample, idling first at random, and hold it until accepted
  task automatic send_item(input logic signed [15:0] code, input logic [31:0] stamp);
    if (items_sent == 217) begin
      send_idle_pct = 56;
      recv_idle_pct = 37;
    end else if (items_sent == 434) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {stamp, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(code, stamp);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic program_regs(input logic [31:0] scale, input logic [31:0] window);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SCALE;
    cfg_data  <= scale;
    @(posedge clk);
    cfg_index <= REG_WINDOW;
    cfg_data  <= window;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(REG_SCALE, scale);
    sb.write_reg(REG_WINDOW, window);
    @(posedge clk);
  endtask

  // Ordered timestamps with random content, plus occasional jumps and rewinds
  task automatic run_ordered(input int unsigned len, input int unsigned win);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 11))
        0:       clock_ms = clock_ms + $urandom_range(0, 2 * win + 10);
        1:       clock_ms = clock_ms - $urandom_range(1, 1000);
        default: clock_ms = clock_ms + $urandom_range(0, win / 8 + 3);
      endcase
      send_item(16'($urandom), clock_ms);
    end
  endtask

  initial begin
    logic [31:0] scale;
    int unsigned win;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: code extremes, window edge, rewind and timestamp wrap
    send_item(16'sd0,      32'd0);
    send_item(16'sd32767,  32'd10);
    send_item(-16'sd32768, 32'd20);
    send_item(-16'sd1,     32'd30);
    send_item(16'sd1,      32'd1000);
    send_item(16'sd2,      32'd1001);
    send_item(16'sd5,      32'd5000);
    send_item(16'sd7,      32'd4000);
    send_item(16'sd100,    32'hFFFF_FF00);
    send_item(-16'sd100,   32'hFFFF_FFFF);
    send_item(16'sd3,      32'h0000_0050);
    drain();

    // Zero window with largest positive gain
    program_regs(32'h7FFF_FFFF, 32'd0);
    send_item(16'sd32767,  32'd100);
    send_item(-16'sd32768, 32'd100);
    send_item(16'sd1,      32'd100);
    send_item(16'sd5,      32'd101);
    drain();

    // Widest window with most negative gain
    program_regs(32'h8000_0000, WIN_MAX);
    send_item(-16'sd32768, 32'd0);
    send_item(16'sd32767,  32'd500000);
    send_item(16'sd1,      32'd1000000);
    send_item(16'sd2,      32'd1000001);
    drain();

    program_regs(32'd0, 32'd5);
    send_item(16'sd1234, 32'd7);
    drain();

    // Fill the store past its depth across the timestamp wrap
    program_regs($urandom, WIN_MAX);
    clock_ms = 32'hFFFF_FF80;
    for (int unsigned i = 0; i < 300; i++) begin
      clock_ms = clock_ms + $urandom_range(0, 3);
      send_item(16'($urandom), clock_ms);
    end
    drain();

    // Random phases until the item budget is spent
    while (items_sent < 650) begin
      case ($urandom_range(0, 4))
        0:       scale = SCALE_RESET;
        1:       scale = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: scale = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0:       win = 0;
        1:       win = $urandom_range(1, 50);
        2:       win = $urandom_range(50, 5000);
        3:       win = WIN_MAX;
        default: win = $urandom_range(0, WIN_MAX);
      endcase
      program_regs(scale, win);
      clock_ms = $urandom;
      if ($urandom_range(0, 4) == 0) begin
        for (int unsigned i = $urandom_range(10, 20); i > 0; i--) begin
          send_item(16'($urandom), $urandom);
        end
      end else begin
        run_ordered($urandom_range(20, 60), win);
      end
      drain();
    end

    repeat (600) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

[files.f]
sv/twsa_pkg.sv
sv/twsa_seq.sv
sv/twsa_div.sv
sv/twsa_dp.sv
sv/time_window_sample_averager.sv
tb/testbench.sv
